// ----- design/stroke_circle_eraser_splitter_macros.svh -----
// ----------------------------------------------------------------------------
// stroke circle eraser splitter assertion macros
// shared property wrappers for the design files
// ----------------------------------------------------------------------------
`ifndef STROKE_CIRCLE_ERASER_SPLITTER_MACROS_SVH
`define STROKE_CIRCLE_ERASER_SPLITTER_MACROS_SVH

// same-cycle implication, muted during reset
`define SCS_ASSERT_NOW(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// next-cycle implication, muted during reset
`define SCS_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

// ----- design/scs_pkg.sv -----
// ----------------------------------------------------------------------------
// scs_pkg
// types, codes and helpers of the stroke circle eraser splitter
// ----------------------------------------------------------------------------
package scs_pkg;

  localparam int COORD_BITS = 16;
  localparam int INDEX_BITS = 24;
  localparam int CFG_BITS   = 32;
  localparam int RAD_BITS   = 32;
  localparam int LW_BITS    = 16;
  localparam int OPND_BITS  = 18;
  localparam int PROD_BITS  = 2 * OPND_BITS;
  localparam int ACC_BITS   = 70;
  localparam int PIECE_BITS = 17;
  localparam int LEN_BITS   = 33;
  localparam int CMAG_BITS  = 34;

  typedef enum logic [1:0] {
    CFG_CENTER_X   = 2'd0,
    CFG_CENTER_Y   = 2'd1,
    CFG_RADIUS_SQ  = 2'd2,
    CFG_LINE_WIDTH = 2'd3
  } cfg_index_t;

  typedef enum logic {
    KIND_RUN = 1'b0,
    KIND_BOX = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    SH_0,
    SH_17,
    SH_18,
    SH_34
  } shift_t;

  typedef struct packed {
    logic   en;
    logic   clr;
    logic   neg;
    shift_t shift;
  } mac_ctl_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SA, ST_SB,
    ST_EA, ST_EB,
    ST_LA, ST_LB,
    ST_DA, ST_DB,
    ST_XA, ST_XB, ST_XC,
    ST_QA, ST_QB, ST_QC,
    ST_RA, ST_RB, ST_RC, ST_RD,
    ST_FIN,
    ST_UPD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic [INDEX_BITS-1:0]        point_index;
    logic                         first_point;
    logic                         last_point;
  } point_t;

  typedef struct packed {
    kind_t                        kind;
    logic [INDEX_BITS-1:0]        run_begin;
    logic [INDEX_BITS:0]          run_end;
    logic                         box_valid;
    logic signed [COORD_BITS-1:0] box_min_x;
    logic signed [COORD_BITS-1:0] box_min_y;
    logic signed [COORD_BITS-1:0] box_max_x;
    logic signed [COORD_BITS-1:0] box_max_y;
    logic                         last_result;
  } result_t;

  function automatic logic signed [COORD_BITS-1:0] smin(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] smax(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    return (a > b) ? a : b;
  endfunction

  // clip an edge widened by the line width back to the coordinate range
  function automatic logic signed [COORD_BITS-1:0] sat_coord(
    input logic signed [COORD_BITS+1:0] v
  );
    logic signed [COORD_BITS+1:0] hi;
    logic signed [COORD_BITS+1:0] lo;
    hi = (COORD_BITS+2)'(2 ** (COORD_BITS - 1) - 1);
    lo = -hi - (COORD_BITS+2)'(1);
    if (v > hi) begin
      return hi[COORD_BITS-1:0];
    end else if (v < lo) begin
      return lo[COORD_BITS-1:0];
    end
    return v[COORD_BITS-1:0];
  endfunction

endpackage

// ----- design/scs_mac.sv -----
// ----------------------------------------------------------------------------
// scs_mac
// shared signed multiplier with shifted add or subtract into an accumulator
// ----------------------------------------------------------------------------
module scs_mac (
  input  logic                                 clk,
  input  logic signed [scs_pkg::OPND_BITS-1:0] op_a,
  input  logic signed [scs_pkg::OPND_BITS-1:0] op_b,
  input  scs_pkg::mac_ctl_t                    ctl,
  output logic signed [scs_pkg::ACC_BITS-1:0]  acc
);
  import scs_pkg::*;

  logic signed [PROD_BITS-1:0] prod;
  logic signed [ACC_BITS-1:0]  prod_ext;
  logic signed [ACC_BITS-1:0]  term;
  logic signed [ACC_BITS-1:0]  shifted;

  assign prod     = op_a * op_b;
  assign prod_ext = ACC_BITS'(prod);

  always_comb begin
    unique case (ctl.shift)
      SH_0:    shifted = prod_ext;
      SH_17:   shifted = prod_ext <<< 17;
      SH_18:   shifted = prod_ext <<< 18;
      SH_34:   shifted = prod_ext <<< 34;
      default: shifted = prod_ext;
    endcase
    term = ctl.neg ? -shifted : shifted;
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc <= ctl.clr ? term : acc + term;
    end
  end

endmodule

// ----- design/stroke_circle_eraser_splitter.sv -----
// ----------------------------------------------------------------------------
// stroke_circle_eraser_splitter
// splits a polyline stroke into kept index runs around an eraser circle and
// reports the widened, saturated box of the erased segments
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  pt       in         pt_valid / pt_stall    scs_pkg::point_t
//  res      out        res_valid / res_stall  scs_pkg::result_t
//  cfg      in         cfg_write              cfg_index, cfg_data
//
// a point is taken in the idle state; a first point goes straight to update and
// emit; any other point runs the segment test on the one shared multiplier and
// leaves early with the start point inside, the end point inside or the foot
// outside the segment, else runs the full perpendicular test of 17 products;
// each result is loaded in its own emit step, which waits while res_stall holds
// rst is synchronous; it clears the sequencer, stroke state, configuration and result flags
// pt_stall is high while a point is in work or its results are queued;
// the result register lets the next point in while a result waits on res_stall
// ----------------------------------------------------------------------------
`include "stroke_circle_eraser_splitter_macros.svh"

module stroke_circle_eraser_splitter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            pt_valid,
  output logic                            pt_stall,
  input  scs_pkg::point_t                 pt_data,
  output logic                            res_valid,
  input  logic                            res_stall,
  output scs_pkg::result_t                res_data,
  input  logic                            cfg_write,
  input  scs_pkg::cfg_index_t             cfg_index,
  input  logic [scs_pkg::CFG_BITS-1:0]    cfg_data
);
  import scs_pkg::*;

  // configuration
  logic signed [COORD_BITS-1:0] center_x;
  logic signed [COORD_BITS-1:0] center_y;
  logic [RAD_BITS-1:0]          radius_sq;
  logic [LW_BITS-1:0]           line_width;

  // stroke state
  logic signed [COORD_BITS-1:0] prev_x;
  logic signed [COORD_BITS-1:0] prev_y;
  logic [INDEX_BITS-1:0]        prev_index;
  logic                         erasing;
  logic [INDEX_BITS-1:0]        open_run_begin;
  logic                         box_seen;
  logic signed [COORD_BITS-1:0] box_bounds [4];

  // work registers
  state_t                       state;
  state_t                       state_next;
  point_t                       pt;
  logic                         hit;
  logic [LEN_BITS-1:0]          len_q;
  logic [CMAG_BITS-1:0]         cmag;
  logic                         run_pend;
  logic                         box_pend;
  logic [INDEX_BITS-1:0]        run_begin_q;
  logic [INDEX_BITS:0]          run_end_q;

  // shared multiplier
  mac_ctl_t                     mac_ctl;
  logic signed [OPND_BITS-1:0]  op_a;
  logic signed [OPND_BITS-1:0]  op_b;
  logic signed [ACC_BITS-1:0]   acc;

  scs_mac u_mac (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .ctl  (mac_ctl),
    .acc  (acc)
  );

  // differences, 17 bits signed
  logic signed [COORD_BITS:0] cxs, cys, cxe, cye, vx, vy;
  assign cxs = {center_x[COORD_BITS-1], center_x} - {prev_x[COORD_BITS-1], prev_x};
  assign cys = {center_y[COORD_BITS-1], center_y} - {prev_y[COORD_BITS-1], prev_y};
  assign cxe = {center_x[COORD_BITS-1], center_x} - {pt.point_x[COORD_BITS-1], pt.point_x};
  assign cye = {center_y[COORD_BITS-1], center_y} - {pt.point_y[COORD_BITS-1], pt.point_y};
  assign vx  = {pt.point_x[COORD_BITS-1], pt.point_x} - {prev_x[COORD_BITS-1], prev_x};
  assign vy  = {pt.point_y[COORD_BITS-1], pt.point_y} - {prev_y[COORD_BITS-1], prev_y};

  // compares against the accumulator
  logic inside_now;
  logic foot_inside;
  assign inside_now  = acc < $signed({{(ACC_BITS-RAD_BITS){1'b0}}, radius_sq});
  assign foot_inside = (acc > $signed(ACC_BITS'(0)))
                    && (acc < $signed({{(ACC_BITS-LEN_BITS){1'b0}}, len_q}));

  logic signed [ACC_BITS-1:0] acc_abs;
  assign acc_abs = acc[ACC_BITS-1] ? -acc : acc;

  logic load_ok;
  assign load_ok  = !res_valid || !res_stall;
  assign pt_stall = (state != ST_IDLE);

  // sequencer: at most one product per step
  always_comb begin
    state_next = state;
    mac_ctl    = '{en: 1'b0, clr: 1'b0, neg: 1'b0, shift: SH_0};
    op_a       = '0;
    op_b       = '0;
    unique case (state)
      ST_IDLE: begin
        if (pt_valid) begin
          state_next = pt_data.first_point ? ST_UPD : ST_SA;
        end
      end
      // start point distance
      ST_SA: begin
        mac_ctl = '{en: 1'b1, clr: 1'b1, neg: 1'b0, shift: SH_0};
        op_a = {cxs[COORD_BITS], cxs}; op_b = {cxs[COORD_BITS], cxs};
        state_next = ST_SB;
      end
      ST_SB: begin
        mac_ctl = '{en: 1'b1, clr: 1'b0, neg: 1'b0, shift: SH_0};
        op_a = {cys[COORD_BITS], cys}; op_b = {cys[COORD_BITS], cys};
        state_next = ST_EA;
      end
      // end point distance
      ST_EA: begin
        mac_ctl = '{en: 1'b1, clr: 1'b1, neg: 1'b0, shift: SH_0};
        op_a = {cxe[COORD_BITS], cxe}; op_b = {cxe[COORD_BITS], cxe};
        state_next = inside_now ? ST_UPD : ST_EB;
      end
      ST_EB: begin
        mac_ctl = '{en: 1'b1, clr: 1'b0, neg: 1'b0, shift: SH_0};
        op_a = {cye[COORD_BITS], cye}; op_b = {cye[COORD_BITS], cye};
        state_next = ST_LA;
      end
      // squared segment length
      ST_LA: begin
        mac_ctl = '{en: 1'b1, clr: 1'b1, neg: 1'b0, shift: SH_0};
        op_a = {vx[COORD_BITS], vx}; op_b = {vx[COORD_BITS], vx};
        state_next = inside_now ? ST_UPD : ST_LB;
      end
      ST_LB: begin
        mac_ctl = '{en: 1'b1, clr: 1'b0, neg: 1'b0, shift: SH_0};
        op_a = {vy[COORD_BITS], vy}; op_b = {vy[COORD_BITS], vy};
        state_next = ST_DA;
      end
      // projection of the centre onto the segment
      ST_DA: begin
        mac_ctl = '{en: 1'b1, clr: 1'b1, neg: 1'b0, shift: SH_0};
        op_a = {cxs[COORD_BITS], cxs}; op_b = {vx[COORD_BITS], vx};
        state_next = ST_DB;
      end
      ST_DB: begin
        mac_ctl = '{en: 1'b1, clr: 1'b0, neg: 1'b0, shift: SH_0};
        op_a = {cys[COORD_BITS], cys}; op_b = {vy[COORD_BITS], vy};
        state_next = ST_XA;
      end
      // cross product
      ST_XA: begin
        mac_ctl = '{en: 1'b1, clr: 1'b1, neg: 1'b0, shift: SH_0};
        op_a = {cxs[COORD_BITS], cxs}; op_b = {vy[COORD_BITS], vy};
        state_next = foot_inside ? ST_XB : ST_UPD;
      end
      ST_XB: begin
        mac_ctl = '{en: 1'b1, clr: 1'b0, neg: 1'b1, shift: SH_0};
        op_a = {cys[COORD_BITS], cys}; op_b = {vx[COORD_BITS], vx};
        state_next = ST_XC;
      end
      ST_XC: begin
        state_next = ST_QA;
      end
      // cross squared, in 17-bit pieces
      ST_QA: begin
        mac_ctl = '{en: 1'b1, clr: 1'b1, neg: 1'b0, shift: SH_34};
        op_a = {1'b0, cmag[CMAG_BITS-1:PIECE_BITS]};
        op_b = {1'b0, cmag[CMAG_BITS-1:PIECE_BITS]};
        state_next = ST_QB;
      end
      ST_QB: begin
        mac_ctl = '{en: 1'b1, clr: 1'b0, neg: 1'b0, shift: SH_18};
        op_a = {1'b0, cmag[CMAG_BITS-1:PIECE_BITS]};
        op_b = {1'b0, cmag[PIECE_BITS-1:0]};
        state_next = ST_QC;
      end
      ST_QC: begin
        mac_ctl = '{en: 1'b1, clr: 1'b0, neg: 1'b0, shift: SH_0};
        op_a = {1'b0, cmag[PIECE_BITS-1:0]};
        op_b = {1'b0, cmag[PIECE_BITS-1:0]};
        state_next = ST_RA;
      end
      // minus radius_sq times length
      ST_RA: begin
        mac_ctl = '{en: 1'b1, clr: 1'b0, neg: 1'b1, shift: SH_0};
        op_a = {1'b0, len_q[PIECE_BITS-1:0]};
        op_b = {1'b0, radius_sq[PIECE_BITS-1:0]};
        state_next = ST_RB;
      end
      ST_RB: begin
        mac_ctl = '{en: 1'b1, clr: 1'b0, neg: 1'b1, shift: SH_17};
        op_a = {1'b0, len_q[PIECE_BITS-1:0]};
        op_b = {3'b000, radius_sq[RAD_BITS-1:PIECE_BITS]};
        state_next = ST_RC;
      end
      ST_RC: begin
        mac_ctl = '{en: 1'b1, clr: 1'b0, neg: 1'b1, shift: SH_17};
        op_a = {2'b00, len_q[LEN_BITS-1:PIECE_BITS]};
        op_b = {1'b0, radius_sq[PIECE_BITS-1:0]};
        state_next = ST_RD;
      end
      ST_RD: begin
        mac_ctl = '{en: 1'b1, clr: 1'b0, neg: 1'b1, shift: SH_34};
        op_a = {2'b00, len_q[LEN_BITS-1:PIECE_BITS]};
        op_b = {3'b000, radius_sq[RAD_BITS-1:PIECE_BITS]};
        state_next = ST_FIN;
      end
      ST_FIN: begin
        state_next = ST_UPD;
      end
      ST_UPD: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!run_pend && !box_pend) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // stroke bookkeeping after the segment decision
  logic                         erasing_next;
  logic [INDEX_BITS-1:0]        open_run_begin_next;
  logic signed [COORD_BITS-1:0] bounds_next [4];
  logic                         seg_hit;

  assign seg_hit = !pt.first_point && hit;

  always_comb begin
    erasing_next        = erasing;
    open_run_begin_next = open_run_begin;
    priority if (pt.first_point) begin
      erasing_next        = 1'b0;
      open_run_begin_next = pt.point_index;
    end else if (hit) begin
      erasing_next = 1'b1;
    end else if (erasing) begin
      erasing_next        = 1'b0;
      open_run_begin_next = prev_index;
    end
    // box of the erased segment, merged with the earlier ones
    bounds_next[0] = smin(prev_x, pt.point_x);
    bounds_next[1] = smin(prev_y, pt.point_y);
    bounds_next[2] = smax(prev_x, pt.point_x);
    bounds_next[3] = smax(prev_y, pt.point_y);
    if (box_seen) begin
      bounds_next[0] = smin(bounds_next[0], box_bounds[0]);
      bounds_next[1] = smin(bounds_next[1], box_bounds[1]);
      bounds_next[2] = smax(bounds_next[2], box_bounds[2]);
      bounds_next[3] = smax(bounds_next[3], box_bounds[3]);
    end
  end

  // result items
  result_t run_item;
  result_t box_item;
  logic signed [COORD_BITS+1:0] lw_ext;

  assign lw_ext = $signed({2'b00, line_width});

  always_comb begin
    run_item           = '0;
    run_item.kind      = KIND_RUN;
    run_item.run_begin = run_begin_q;
    run_item.run_end   = run_end_q;

    box_item             = '0;
    box_item.kind        = KIND_BOX;
    box_item.last_result = 1'b1;
    if (box_seen) begin
      box_item.box_valid = 1'b1;
      box_item.box_min_x = sat_coord(
        $signed({{2{box_bounds[0][COORD_BITS-1]}}, box_bounds[0]}) - lw_ext);
      box_item.box_min_y = sat_coord(
        $signed({{2{box_bounds[1][COORD_BITS-1]}}, box_bounds[1]}) - lw_ext);
      box_item.box_max_x = sat_coord(
        $signed({{2{box_bounds[2][COORD_BITS-1]}}, box_bounds[2]}) + lw_ext);
      box_item.box_max_y = sat_coord(
        $signed({{2{box_bounds[3][COORD_BITS-1]}}, box_bounds[3]}) + lw_ext);
    end
  end

  logic emit_now;
  assign emit_now = (state == ST_EMIT) && (run_pend || box_pend);

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && pt_valid) begin
      pt <= pt_data;
    end
    if (state == ST_DA) begin
      len_q <= acc[LEN_BITS-1:0];
    end
    if (state == ST_XC) begin
      cmag <= acc_abs[CMAG_BITS-1:0];
    end
    if (state == ST_UPD) begin
      run_begin_q <= open_run_begin_next;
      run_end_q   <= seg_hit ? {1'b0, pt.point_index}
                             : {1'b0, pt.point_index} + (INDEX_BITS+1)'(1);
    end
    if (load_ok && emit_now) begin
      res_data <= run_pend ? run_item : box_item;
    end
  end

  // control and stroke state
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x       <= '0;
      center_y       <= '0;
      radius_sq      <= '0;
      line_width     <= '0;
      prev_x         <= '0;
      prev_y         <= '0;
      prev_index     <= '0;
      erasing        <= 1'b0;
      open_run_begin <= '0;
      box_seen       <= 1'b0;
      box_bounds     <= '{default: '0};
      hit            <= 1'b0;
      run_pend       <= 1'b0;
      box_pend       <= 1'b0;
      res_valid      <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_CENTER_X:   center_x   <= cfg_data[COORD_BITS-1:0];
          CFG_CENTER_Y:   center_y   <= cfg_data[COORD_BITS-1:0];
          CFG_RADIUS_SQ:  radius_sq  <= cfg_data[RAD_BITS-1:0];
          CFG_LINE_WIDTH: line_width <= cfg_data[LW_BITS-1:0];
          default: ;
        endcase
      end

      // segment decision
      unique case (state)
        ST_IDLE: hit <= 1'b0;
        ST_EA:   hit <= inside_now;
        ST_LA:   hit <= inside_now;
        ST_FIN:  hit <= acc[ACC_BITS-1];
        default: ;
      endcase

      if (state == ST_UPD) begin
        erasing        <= erasing_next;
        open_run_begin <= open_run_begin_next;
        prev_x         <= pt.point_x;
        prev_y         <= pt.point_y;
        prev_index     <= pt.point_index;
        if (pt.first_point) begin
          box_seen   <= 1'b0;
          box_bounds <= '{default: '0};
        end else if (hit) begin
          box_seen   <= 1'b1;
          box_bounds <= bounds_next;
        end
        // a kept run closes at a hit while not erasing, or at the last point when erasing_next is clear
        run_pend <= (seg_hit && !erasing) || (pt.last_point && !erasing_next);
        box_pend <= pt.last_point;
      end

      // result register transfer
      if (load_ok) begin
        res_valid <= emit_now;
        if (emit_now) begin
          if (run_pend) begin
            run_pend <= 1'b0;
          end else begin
            box_pend <= 1'b0;
          end
        end
      end
    end
  end

  // a point is only taken once no result of the previous point is still pending
  `SCS_ASSERT_NOW(a_no_pending_on_take, clk, rst, pt_valid && !pt_stall, !run_pend && !box_pend, "point taken with results pending")
  // a closing point always queues its box result
  `SCS_ASSERT_NEXT(a_last_queues_box, clk, rst, state == ST_UPD && pt.last_point, box_pend, "box result not queued for last point")
  // an empty box comes out with zero edges
  `SCS_ASSERT_NOW(a_empty_box_zero, clk, rst, res_valid && res_data.kind == KIND_BOX && !res_data.box_valid, res_data.box_min_x == '0 && res_data.box_max_y == '0, "empty box has nonzero edges")

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the stroke circle eraser splitter: feeds polyline
// strokes around a configured eraser circle, predicts the kept runs and the
// widened erase box of every stroke, and compares each result transfer in order
// ----------------------------------------------------------------------------
module tb_top;
  import scs_pkg::*;

  localparam int SETTLE_CYCLES = 64;       // worst point latency plus margin
  localparam int HOLD_CYCLES   = 600;      // long receiver hold-off
  localparam int CYCLE_LIMIT   = 1000000;  // watchdog
  localparam int PHASE_ITEMS   = 165;      // random points per config phase

  // dut ports, every input known from time zero
  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  pt_valid  = 1'b0;
  logic                  pt_stall;
  point_t                pt_data   = '0;
  logic                  res_valid;
  logic                  res_stall = 1'b0;
  result_t               res_data;
  logic                  cfg_write = 1'b0;
  cfg_index_t            cfg_index = CFG_CENTER_X;
  logic [CFG_BITS-1:0]   cfg_data  = '0;

  // stimulus and expected result stores
  point_t                point_backlog[$];
  result_t               pending_results[$];

  // idle percentages, changed between phases
  int                    send_idle   = 37;
  int                    recv_idle   = 81;
  int                    err_count   = 0;
  int                    cycle_count = 0;

  // long hold-off, counted in its own process
  logic                  hold_go   = 1'b0;
  logic                  hold_done = 1'b0;
  int                    hold_left = 0;

  // eraser configuration as the block should hold it
  int                    cen_x   = 0;
  int                    cen_y   = 0;
  longint                rad_sq  = 0;
  int                    lw      = 0;
  int                    rad_root = 0;

  // stroke state of the predictor
  int                    last_x   = 0;
  int                    last_y   = 0;
  logic [INDEX_BITS-1:0] last_idx = '0;
  logic [INDEX_BITS-1:0] run_start = '0;
  bit                    in_erase = 1'b0;
  bit                    have_box = 1'b0;
  int                    bnd[4]   = '{0, 0, 0, 0};  // min x, min y, max x, max y

  stroke_circle_eraser_splitter u_top (
    .clk       (clk),
    .rst       (rst),
    .pt_valid  (pt_valid),
    .pt_stall  (pt_stall),
    .pt_data   (pt_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // ------------------------------------------------------------------------
  // predictor
  // ------------------------------------------------------------------------

  // strictly inside the circle, squared distance against squared radius
  function automatic bit covers(int px, int py);
    longint dx;
    longint dy;
    dx = cen_x - px;
    dy = cen_y - py;
    return (dx * dx + dy * dy) < rad_sq;
  endfunction

  // endpoint test, then perpendicular foot strictly inside and close enough
  function automatic bit segment_erased(int sx, int sy, int ex, int ey);
    longint     vx;
    longint     vy;
    longint     cx;
    longint     cy;
    longint     seg_len;
    longint     dot;
    longint     cross_v;
    logic [127:0] cm;
    logic [127:0] lhs;
    logic [127:0] rhs;
    if (covers(sx, sy) || covers(ex, ey)) begin
      return 1'b1;
    end
    vx = ex - sx;
    vy = ey - sy;
    cx = cen_x - sx;
    cy = cen_y - sy;
    seg_len = vx * vx + vy * vy;
    dot = cx * vx + cy * vy;
    // degenerate segments fall out here since dot and length are both zero
    if (dot <= 0 || dot >= seg_len) begin
      return 1'b0;
    end
    cross_v = cx * vy - cy * vx;
    if (cross_v < 0) begin
      cross_v = -cross_v;
    end
    cm  = 128'(cross_v);
    lhs = cm * cm;
    rhs = 128'(seg_len) * 128'(rad_sq);
    return lhs < rhs;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] clip_coord(int v);
    if (v > 32767) begin
      return 16'sh7FFF;
    end
    if (v < -32768) begin
      return 16'sh8000;
    end
    return v[COORD_BITS-1:0];
  endfunction

  function automatic result_t run_item(logic [INDEX_BITS-1:0] b, logic [INDEX_BITS:0] e);
    result_t r;
    r = '0;
    r.kind      = KIND_RUN;
    r.run_begin = b;
    r.run_end   = e;
    return r;
  endfunction

  // append to the expected results, oldest first
  task automatic queue_result(result_t r);
    pending_results = {pending_results, r};
  endtask

  task automatic grow_box(int x, int y);
    if (x < bnd[0]) bnd[0] = x;
    if (y < bnd[1]) bnd[1] = y;
    if (x > bnd[2]) bnd[2] = x;
    if (y > bnd[3]) bnd[3] = y;
  endtask

  // one accepted point: update stroke state and queue the results it causes
  task automatic predict_point(point_t p);
    int                    x;
    int                    y;
    logic [INDEX_BITS-1:0] idx;
    result_t               r;
    x   = $signed(p.point_x);
    y   = $signed(p.point_y);
    idx = p.point_index;
    if (p.first_point) begin
      // restart, any unfinished stroke is dropped silently
      in_erase  = 1'b0;
      have_box  = 1'b0;
      run_start = idx;
      bnd       = '{0, 0, 0, 0};
    end else if (segment_erased(last_x, last_y, x, y)) begin
      if (!have_box) begin
        bnd[0]   = last_x;
        bnd[2]   = last_x;
        bnd[1]   = last_y;
        bnd[3]   = last_y;
        have_box = 1'b1;
      end
      grow_box(last_x, last_y);
      grow_box(x, y);
      // a kept run closes at the first erased segment, start point included
      if (!in_erase) begin
        queue_result(run_item(run_start, {1'b0, idx}));
        in_erase = 1'b1;
      end
    end else if (in_erase) begin
      // kept again: new run opens at this segment's start point
      run_start = last_idx;
      in_erase  = 1'b0;
    end
    last_x   = x;
    last_y   = y;
    last_idx = idx;
    if (p.last_point) begin
      // run end is index plus one, carried into the extra bit
      if (!in_erase) begin
        queue_result(run_item(run_start, {1'b0, idx} + (INDEX_BITS+1)'(1)));
      end
      r = '0;
      r.kind        = KIND_BOX;
      r.last_result = 1'b1;
      if (have_box) begin
        r.box_valid = 1'b1;
        r.box_min_x = clip_coord(bnd[0] - lw);
        r.box_min_y = clip_coord(bnd[1] - lw);
        r.box_max_x = clip_coord(bnd[2] + lw);
        r.box_max_y = clip_coord(bnd[3] + lw);
      end
      queue_result(r);
    end
  endtask

  // ------------------------------------------------------------------------
  // checking
  // ------------------------------------------------------------------------

  task automatic report(string what);
    err_count++;
    if (err_count <= 100) begin
      $display("mismatch at cycle %0d: %s", cycle_count, what);
    end
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report($sformatf("%s got %0h want %0h", name, got, want));
    end
  endtask

  // ------------------------------------------------------------------------
  // driver: point transfers from the backlog, random gaps between them
  // ------------------------------------------------------------------------
  always @(posedge clk) begin : point_driver
    bit took;
    if (rst) begin
      pt_valid <= 1'b0;
    end else begin
      took = pt_valid && !pt_stall;
      if (took) begin
        predict_point(pt_data);
      end
      // a held payload stays put until its transfer
      if (!pt_valid || took) begin
        if (point_backlog.size() != 0 && $urandom_range(99) >= send_idle) begin
          pt_data  <= point_backlog.pop_front();
          pt_valid <= 1'b1;
        end else begin
          pt_valid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // monitor: compare each result transfer with the oldest expectation
  // ------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    result_t want;
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (pending_results.size() == 0) begin
          report($sformatf("result with nothing expected, kind %0d", res_data.kind));
        end else begin
          want = pending_results.pop_front();
          check_field("kind", res_data.kind, want.kind);
          check_field("run_begin", res_data.run_begin, want.run_begin);
          check_field("run_end", res_data.run_end, want.run_end);
          check_field("box_valid", res_data.box_valid, want.box_valid);
          check_field("box_min_x", res_data.box_min_x, want.box_min_x);
          check_field("box_min_y", res_data.box_min_y, want.box_min_y);
          check_field("box_max_x", res_data.box_max_x, want.box_max_x);
          check_field("box_max_y", res_data.box_max_y, want.box_max_y);
          check_field("last_result", res_data.last_result, want.last_result);
        end
      end
      res_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle);
    end
  end

  // long hold-off so the block backs up and stalls its input
  always @(posedge clk) begin : hold_counter
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // watchdog
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------------

  // append to the point backlog, sent in order
  task automatic queue_point(point_t p);
    point_backlog = {point_backlog, p};
  endtask

  task automatic add_pt(int x, int y, logic [INDEX_BITS-1:0] idx, bit first, bit last);
    point_t p;
    p.point_x     = x[COORD_BITS-1:0];
    p.point_y     = y[COORD_BITS-1:0];
    p.point_index = idx;
    p.first_point = first;
    p.last_point  = last;
    queue_point(p);
  endtask

  // register write, mirrored into the predictor while the block is idle
  task automatic write_reg(cfg_index_t i, logic [CFG_BITS-1:0] v);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= i;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (i)
      CFG_CENTER_X:   cen_x  = $signed(v[COORD_BITS-1:0]);
      CFG_CENTER_Y:   cen_y  = $signed(v[COORD_BITS-1:0]);
      CFG_RADIUS_SQ:  rad_sq = longint'(v);
      CFG_LINE_WIDTH: lw     = v[LW_BITS-1:0];
      default:        ;
    endcase
  endtask

  task automatic set_config(int cx, int cy, logic [31:0] rsq, int w);
    write_reg(CFG_CENTER_X, 32'(cx));
    write_reg(CFG_CENTER_Y, 32'(cy));
    write_reg(CFG_RADIUS_SQ, rsq);
    write_reg(CFG_LINE_WIDTH, 32'(w));
  endtask

  function automatic int pick_center();
    case ($urandom_range(7))
      0:       return -32768;
      1:       return 32767;
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  task automatic random_config();
    int          cx;
    int          cy;
    int          w;
    logic [31:0] rsq;
    cx = pick_center();
    cy = pick_center();
    case ($urandom_range(5))
      0: begin
        rad_root = 0;
        rsq      = 32'd0;
      end
      1: begin
        rad_root = 65535;
        rsq      = 32'hFFFF_FFFF;
      end
      default: begin
        rad_root = $urandom_range(1, 3000);
        rsq      = 32'(rad_root * rad_root) + $urandom_range(0, rad_root);
      end
    endcase
    case ($urandom_range(4))
      0:       w = 0;
      1:       w = 65535;
      default: w = $urandom_range(0, 300);
    endcase
    set_config(cx, cy, rsq, w);
  endtask

  // random coordinate around c, clipped to the coordinate range
  function automatic int near(int c, int s);
    int v;
    v = c + int'($urandom_range(0, 2 * s)) - s;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  // mostly well-formed strokes around the circle, some noise and broken ones
  task automatic queue_random(int n_items);
    int                    made;
    int                    len;
    int                    k;
    int                    mode;
    int                    scale;
    int                    x;
    int                    y;
    logic [INDEX_BITS-1:0] idx;
    bit                    no_first;
    bit                    no_last;
    point_t                p;
    made = 0;
    x    = 0;
    y    = 0;
    while (made < n_items) begin
      mode = $urandom_range(99);
      if (mode < 10) begin
        // noise: every field random
        p.point_x     = COORD_BITS'($urandom);
        p.point_y     = COORD_BITS'($urandom);
        p.point_index = INDEX_BITS'($urandom);
        p.first_point = 1'($urandom);
        p.last_point  = 1'($urandom);
        queue_point(p);
        made++;
      end else begin
        no_first = (mode < 15);
        no_last  = (mode >= 15 && mode < 20);
        len      = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
        if ($urandom_range(4) == 0 || rad_root == 0) begin
          scale = ($urandom_range(1) == 0) ? 32768 : $urandom_range(100, 2000);
        end else begin
          scale = rad_root * $urandom_range(1, 3) + $urandom_range(1, 64);
        end
        idx = ($urandom_range(15) == 0) ? INDEX_BITS'(24'hFFFFFF - $urandom_range(5))
                                        : INDEX_BITS'($urandom);
        for (k = 0; k < len; k++) begin
          // now and then a repeated point for a degenerate segment
          if (k == 0 || $urandom_range(9) != 0) begin
            x = near(cen_x, scale);
            y = near(cen_y, scale);
          end
          add_pt(x, y, idx, (k == 0) && !no_first, (k == len - 1) && !no_last);
          idx++;
          made++;
        end
      end
    end
  endtask

  // wait for the backlog, the block and the expectations to drain, then settle
  task automatic wait_idle();
    @(negedge clk);
    while (point_backlog.size() != 0 || pt_valid || pt_stall || res_valid
           || pending_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ------------------------------------------------------------------------
  // test sequence
  // ------------------------------------------------------------------------
  initial begin : stimulus
    int ph;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset config: a point with no stroke start measures from the origin
    add_pt(100, 50, 5, 1'b0, 1'b1);
    wait_idle();

    set_config(0, 0, 32'd25600, 32);
    // perpendicular hit in mid segment, then kept again
    add_pt(-1000, 0, 10, 1'b1, 1'b0);
    add_pt(-500, 0, 11, 1'b0, 1'b0);
    add_pt(500, 0, 12, 1'b0, 1'b0);
    add_pt(1000, 0, 13, 1'b0, 1'b0);
    add_pt(1000, 1000, 14, 1'b0, 1'b1);
    // hit on the first segment gives a one-point run
    add_pt(0, 0, 20, 1'b1, 1'b0);
    add_pt(300, 0, 21, 1'b0, 1'b0);
    add_pt(300, 300, 22, 1'b0, 1'b1);
    // single point stroke
    add_pt(5, 5, 30, 1'b1, 1'b1);
    // degenerate segment outside, abandoned by a new first point
    add_pt(1000, 1000, 40, 1'b1, 1'b0);
    add_pt(1000, 1000, 41, 1'b0, 1'b0);
    // degenerate segment inside, then more points after the last mark
    add_pt(10, 10, 43, 1'b1, 1'b0);
    add_pt(10, 10, 44, 1'b0, 1'b1);
    add_pt(200, -100, 45, 1'b0, 1'b0);
    add_pt(2000, -2000, 46, 1'b0, 1'b1);
    // run end past the top index
    add_pt(3000, 3000, 24'hFFFFFE, 1'b1, 1'b0);
    add_pt(3100, 3000, 24'hFFFFFF, 1'b0, 1'b1);
    wait_idle();

    // extremes: corner centre, widest radius and width, saturating box
    set_config(32767, -32768, 32'hFFFF_FFFF, 65535);
    add_pt(-32768, 32767, 0, 1'b1, 1'b0);
    add_pt(32767, -32768, 1, 1'b0, 1'b0);
    add_pt(32767, 32767, 2, 1'b0, 1'b1);
    add_pt(-32768, -32768, 3, 1'b1, 1'b1);
    wait_idle();

    // random phases: receiver idles more, then sender, then neither
    for (ph = 0; ph < 6; ph++) begin
      random_config();
      if (ph < 2) begin
        send_idle = 37;
        recv_idle = 81;
      end else if (ph < 4) begin
        send_idle = 81;
        recv_idle = 37;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      queue_random(PHASE_ITEMS);
      if (ph == 4) begin
        hold_go <= 1'b1;
      end
      wait_idle();
    end

    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
